/* rtl/lru_writeback_key_cache_top_assert.svh */
// assertion macros for the lru write-back key cache
`ifndef LRU_WRITEBACK_KEY_CACHE_TOP_ASSERT_SVH
`define LRU_WRITEBACK_KEY_CACHE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LWKC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lwkc assertion failed");
`define LWKC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("lwkc assertion failed");
`else
`define LWKC_ASSERT(lbl, prop)
`define LWKC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* rtl/lwkc_pkg.sv */
// types and constants shared by the key cache modules
`timescale 1ns / 1ps
`default_nettype none
package lwkc_pkg;
    localparam int MAX_ENTRIES = 16;
    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;

    typedef enum logic [1:0] {
        REQ_GET   = 2'd0,
        REQ_SET   = 2'd1,
        REQ_FILL  = 2'd2,
        REQ_FLUSH = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        K_GET_HIT    = 3'd0,
        K_SET_DONE   = 3'd1,
        K_FETCH      = 3'd2,
        K_WRITEBACK  = 3'd3,
        K_FILL_DONE  = 3'd4,
        K_FILL_FAIL  = 3'd5,
        K_FLUSH_DONE = 3'd6
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CMP, S_HIT, S_MISS, S_EVCHK, S_EVWB, S_INS
    } t_state;

    typedef enum logic [1:0] {
        CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR
    } t_cnt_op;

    typedef struct packed {
        logic              rot;
        logic [SLOT_W-1:0] rot_from;
        logic [SLOT_W-1:0] rot_to;
        t_cnt_op           cnt_op;
    } t_ord_cmd;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_key;
        logic [VAL_W-1:0]  wr_val;
        logic              wr_dirty;
        logic              clr_dirty;
    } t_mem_cmd;
endpackage
`default_nettype wire

/* rtl/lru_writeback_key_cache_top.sv */
// top level: request sequencer around the entry memory and recency list
//
//  channel   signals                                   handshake
//  request   i_req_type i_key i_value i_fill_ok        start && !busy
//  result    o_kind o_out_key o_out_value o_last       o_res_valid, one cycle
//  config    i_cfg_data (capacity in use)              i_cfg_valid && o_cfg_ready
//
// a lookup walks the recency list, reading memory then comparing the key for each
// occupied entry, then resolves as a hit or a miss; an insert first evicts the oldest
// entries while full, writing back dirty ones. a flush reads and checks every occupied entry.
// results come from a register and cannot be held off.
// reset is synchronous; the cache comes up empty, no clearing pass is needed.
// config is taken only while busy is low.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_writeback_key_cache_top_assert.svh"
module lru_writeback_key_cache_top import lwkc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       i_req_type,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [VAL_W-1:0] i_value,
    input  wire logic             i_fill_ok,
    output logic                  o_res_valid,
    output logic [2:0]            o_kind,
    output logic [KEY_W-1:0]      o_out_key,
    output logic [VAL_W-1:0]      o_out_value,
    output logic                  o_last,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CAP_W-1:0] i_cfg_data
);
    t_state            r_state, n_state;
    t_req              r_type, n_type;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [SLOT_W-1:0] r_hitpos, n_hitpos;
    logic [KEY_W-1:0]  r_pkey, n_pkey;
    logic              r_pvalid, n_pvalid;
    logic [CAP_W-1:0]  r_cap;
    logic              r_ovalid, n_ovalid;
    t_kind             r_kind, n_kind;
    logic [KEY_W-1:0]  r_okey, n_okey;
    logic [VAL_W-1:0]  r_oval, n_oval;
    logic              r_olast, n_olast;

    t_ord_cmd          w_ord;
    t_mem_cmd          w_mem;
    logic [SLOT_W-1:0] w_sel_pos, w_sel_slot, w_newest;
    logic [CNT_W-1:0]  w_count, w_cap;
    logic              w_dirty, w_evict, w_scan_end, w_match;
    logic [KEY_W-1:0]  w_rd_key;
    logic [VAL_W-1:0]  w_rd_val;

    lwkc_order u_order (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_ord),
        .i_sel_pos  (w_sel_pos),
        .o_sel_slot (w_sel_slot),
        .o_count    (w_count)
    );

    lwkc_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_mem),
        .i_dirty_addr (w_sel_slot),
        .o_dirty      (w_dirty),
        .o_rd_key     (w_rd_key),
        .o_rd_val     (w_rd_val)
    );

    // zero acts as one, anything above the table size as the table size
    always_comb begin
        if (r_cap == '0) begin
            w_cap = CNT_W'(1);
        end else if (CNT_W'(r_cap) > CNT_W'(MAX_ENTRIES)) begin
            w_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            w_cap = CNT_W'(r_cap);
        end
    end

    assign w_evict    = (w_count != '0) && (w_count >= w_cap);
    assign w_scan_end = (r_pos >= w_count);
    assign w_match    = (w_rd_key == r_key);
    assign w_newest   = SLOT_W'(w_count - CNT_W'(1));
    assign busy       = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;

    always_comb begin
        case (r_state)
            S_INS:            w_sel_pos = w_count[SLOT_W-1:0];
            S_HIT:            w_sel_pos = r_hitpos;
            S_EVCHK, S_EVWB:  w_sel_pos = '0;
            default:          w_sel_pos = r_pos[SLOT_W-1:0];
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (t_req'(i_req_type) == REQ_FILL && (!r_pvalid || !i_fill_ok)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = (r_type == REQ_FLUSH) ? S_IDLE : S_MISS;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_type != REQ_FLUSH && w_match) begin
                    n_state = S_HIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_HIT:  n_state = S_IDLE;
            S_MISS: n_state = (r_type == REQ_GET) ? S_IDLE : S_EVCHK;
            S_EVCHK: begin
                if (!w_evict) begin
                    n_state = S_INS;
                end else if (w_dirty) begin
                    n_state = S_EVWB;
                end
            end
            S_EVWB: n_state = S_EVCHK;
            S_INS:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory and list commands, results
    always_comb begin
        n_type   = r_type;
        n_key    = r_key;
        n_val    = r_val;
        n_pos    = r_pos;
        n_hitpos = r_hitpos;
        n_pkey   = r_pkey;
        n_pvalid = r_pvalid;
        n_ovalid = 1'b0;
        n_kind   = r_kind;
        n_okey   = r_okey;
        n_oval   = r_oval;
        n_olast  = 1'b0;
        w_ord    = '{rot: 1'b0, rot_from: '0, rot_to: '0, cnt_op: CNT_HOLD};
        w_mem    = '0;
        w_mem.rd_addr = w_sel_slot;
        w_mem.wr_addr = w_sel_slot;
        w_mem.wr_key  = r_key;
        w_mem.wr_val  = r_val;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_type = t_req'(i_req_type);
                    n_key  = i_key;
                    n_val  = i_value;
                    n_pos  = '0;
                    if (t_req'(i_req_type) == REQ_FILL) begin
                        if (!r_pvalid) begin
                            n_ovalid = 1'b1;
                            n_kind   = K_FILL_FAIL;
                            n_okey   = i_key;
                            n_oval   = '0;
                            n_olast  = 1'b1;
                        end else begin
                            // a fill always answers the pending miss
                            n_pvalid = 1'b0;
                            n_key    = r_pkey;
                            if (!i_fill_ok) begin
                                n_ovalid = 1'b1;
                                n_kind   = K_FILL_FAIL;
                                n_okey   = r_pkey;
                                n_oval   = '0;
                                n_olast  = 1'b1;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    if (r_type == REQ_FLUSH) begin
                        w_ord.cnt_op    = CNT_CLR;
                        w_mem.clr_dirty = 1'b1;
                        n_ovalid = 1'b1;
                        n_kind   = K_FLUSH_DONE;
                        n_okey   = r_key;
                        n_oval   = '0;
                        n_olast  = 1'b1;
                    end
                end else begin
                    w_mem.rd_en = 1'b1;
                end
            end
            S_CMP: begin
                n_pos = r_pos + CNT_W'(1);
                if (r_type == REQ_FLUSH) begin
                    if (w_dirty) begin
                        n_ovalid = 1'b1;
                        n_kind   = K_WRITEBACK;
                        n_okey   = w_rd_key;
                        n_oval   = w_rd_val;
                    end
                end else if (w_match) begin
                    n_hitpos = r_pos[SLOT_W-1:0];
                end
            end
            S_HIT: begin
                w_ord.rot      = 1'b1;
                w_ord.rot_from = r_hitpos;
                w_ord.rot_to   = w_newest;
                n_ovalid = 1'b1;
                n_olast  = 1'b1;
                n_okey   = r_key;
                case (r_type)
                    REQ_GET: begin
                        n_kind = K_GET_HIT;
                        n_oval = w_rd_val;
                    end
                    REQ_SET: begin
                        w_mem.wr_en    = 1'b1;
                        w_mem.wr_dirty = 1'b1;
                        n_kind = K_SET_DONE;
                        n_oval = r_val;
                    end
                    default: begin
                        n_kind = K_FILL_DONE;
                        n_oval = w_rd_val;
                    end
                endcase
            end
            S_MISS: begin
                if (r_type == REQ_GET) begin
                    n_pkey   = r_key;
                    n_pvalid = 1'b1;
                    n_ovalid = 1'b1;
                    n_kind   = K_FETCH;
                    n_okey   = r_key;
                    n_oval   = '0;
                    n_olast  = 1'b1;
                end
            end
            S_EVCHK: begin
                if (w_evict) begin
                    if (w_dirty) begin
                        w_mem.rd_en = 1'b1;
                    end else begin
                        // clean victim drops silently
                        w_ord.rot    = 1'b1;
                        w_ord.rot_to = w_newest;
                        w_ord.cnt_op = CNT_DEC;
                    end
                end
            end
            S_EVWB: begin
                w_ord.rot    = 1'b1;
                w_ord.rot_to = w_newest;
                w_ord.cnt_op = CNT_DEC;
                n_ovalid = 1'b1;
                n_kind   = K_WRITEBACK;
                n_okey   = w_rd_key;
                n_oval   = w_rd_val;
            end
            S_INS: begin
                w_mem.wr_en    = 1'b1;
                w_mem.wr_dirty = (r_type == REQ_SET);
                w_ord.cnt_op   = CNT_INC;
                n_ovalid = 1'b1;
                n_kind   = (r_type == REQ_SET) ? K_SET_DONE : K_FILL_DONE;
                n_okey   = r_key;
                n_oval   = r_val;
                n_olast  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pvalid <= 1'b0;
            r_pkey   <= '0;
            r_cap    <= CAP_W'(MAX_ENTRIES);
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pvalid <= n_pvalid;
            r_pkey   <= n_pkey;
            r_ovalid <= n_ovalid;
            r_olast  <= n_olast;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type   <= n_type;
        r_key    <= n_key;
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_hitpos <= n_hitpos;
        r_kind   <= n_kind;
        r_okey   <= n_okey;
        r_oval   <= n_oval;
    end

    assign o_res_valid = r_ovalid;
    assign o_kind      = r_kind;
    assign o_out_key   = r_okey;
    assign o_out_value = r_oval;
    assign o_last      = r_olast;

    `LWKC_ASSERT(a_last_ends_item, (o_res_valid && o_last) |-> !busy)
    `LWKC_ASSERT(a_accept_goes_busy, (start && !busy && t_req'(i_req_type) == REQ_GET) |=> busy)
    `LWKC_ASSERT(a_insert_has_room, (r_state == S_INS) |-> (w_count < CNT_W'(MAX_ENTRIES)))
    `LWKC_ASSERT_ALWAYS(a_count_bounded, !i_rst_n || (w_count <= CNT_W'(MAX_ENTRIES)))
endmodule
`default_nettype wire

/* rtl/lwkc_store.sv */
// entry memory (key and value per slot) with per-slot dirty bits
`timescale 1ns / 1ps
`default_nettype none
module lwkc_store import lwkc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mem_cmd          i_cmd,
    input  wire logic [SLOT_W-1:0] i_dirty_addr,
    output logic                   o_dirty,
    output logic [KEY_W-1:0]       o_rd_key,
    output logic [VAL_W-1:0]       o_rd_val
);
    logic [KEY_W+VAL_W-1:0] mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_dirty;
    logic [KEY_W+VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_cmd.wr_addr] <= {i_cmd.wr_key, i_cmd.wr_val};
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= '0;
        end else if (i_cmd.clr_dirty) begin
            r_dirty <= '0;
        end else if (i_cmd.wr_en) begin
            r_dirty[i_cmd.wr_addr] <= i_cmd.wr_dirty;
        end
    end

    assign o_dirty  = r_dirty[i_dirty_addr];
    assign o_rd_key = r_rdata[KEY_W+VAL_W-1:VAL_W];
    assign o_rd_val = r_rdata[VAL_W-1:0];
endmodule
`default_nettype wire

/* rtl/lwkc_order.sv */
// recency list of slot numbers (oldest first) and occupancy count
`timescale 1ns / 1ps
`default_nettype none
module lwkc_order import lwkc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ord_cmd          i_cmd,
    input  wire logic [SLOT_W-1:0] i_sel_pos,
    output logic [SLOT_W-1:0]      o_sel_slot,
    output logic [CNT_W-1:0]       o_count
);
    logic [SLOT_W-1:0] r_order [MAX_ENTRIES];
    logic [SLOT_W-1:0] n_order [MAX_ENTRIES];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    // rotate positions from..to left by one, entry at from goes to to
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_order[i] = r_order[i];
            if (i_cmd.rot) begin
                if (SLOT_W'(i) == i_cmd.rot_to) begin
                    n_order[i] = r_order[i_cmd.rot_from];
                end else if (SLOT_W'(i) >= i_cmd.rot_from && SLOT_W'(i) < i_cmd.rot_to) begin
                    n_order[i] = r_order[SLOT_W'(i + 1)];
                end
            end
        end
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CNT_W'(1);
            CNT_DEC: n_count = r_count - CNT_W'(1);
            CNT_CLR: n_count = '0;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_order[i] <= SLOT_W'(i);
            end
        end else begin
            r_count <= n_count;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_order[i] <= n_order[i];
            end
        end
    end

    assign o_sel_slot = r_order[i_sel_pos];
    assign o_count    = r_count;
endmodule
`default_nettype wire

/* verif/lru_writeback_key_cache_top_tb.sv */
// testbench for the lru write-back key cache: shadow cache predicts results, monitor checks them
`timescale 1ns / 1ps
module lru_writeback_key_cache_top_tb;
    import lwkc_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 80;

    typedef struct {
        t_kind            kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_cache_word;

    // shadow copy of the cache contents, oldest entry in slot 0
    class key_cache_shadow;
        logic [KEY_W-1:0] keys [MAX_ENTRIES];
        logic [VAL_W-1:0] vals [MAX_ENTRIES];
        logic             dirty [MAX_ENTRIES];
        int               used;
        logic [KEY_W-1:0] miss_key;
        logic             miss_valid;
        logic [CAP_W-1:0] capacity;
        t_cache_word      awaited [$];
        t_cache_word      burst [$];
        int               errors;

        function new();
            used = 0;
            miss_key = '0;
            miss_valid = 1'b0;
            capacity = CAP_W'(16);
            errors = 0;
            foreach (dirty[i]) dirty[i] = 1'b0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            capacity = c;
        endfunction

        function int slots_allowed();
            if (capacity == 0) return 1;
            if (capacity > MAX_ENTRIES) return MAX_ENTRIES;
            return int'(capacity);
        endfunction

        function void push(t_kind k, logic [KEY_W-1:0] key, logic [VAL_W-1:0] v);
            t_cache_word w;
            w.kind = k;
            w.key = key;
            w.value = v;
            w.last = 1'b0;
            burst.push_back(w);
        endfunction

        function int lookup(logic [KEY_W-1:0] key);
            for (int i = 0; i < used; i++)
                if (keys[i] == key) return i;
            return -1;
        endfunction

        function void shift_down(int from);
            for (int i = from; i + 1 < used; i++) begin
                keys[i] = keys[i+1];
                vals[i] = vals[i+1];
                dirty[i] = dirty[i+1];
            end
        endfunction

        function void touch(int slot);
            logic [KEY_W-1:0] k;
            logic [VAL_W-1:0] v;
            logic             d;
            k = keys[slot];
            v = vals[slot];
            d = dirty[slot];
            shift_down(slot);
            keys[used-1] = k;
            vals[used-1] = v;
            dirty[used-1] = d;
        endfunction

        // evict oldest until one slot is free, then append
        function void insert(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v, logic d);
            while (used > 0 && used >= slots_allowed()) begin
                if (dirty[0]) push(K_WRITEBACK, keys[0], vals[0]);
                shift_down(0);
                used--;
            end
            keys[used] = k;
            vals[used] = v;
            dirty[used] = d;
            used++;
        endfunction

        function void note_request(t_req req, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] v, logic ok);
            int slot;
            logic [KEY_W-1:0] pk;
            burst.delete();
            case (req)
                REQ_GET: begin
                    slot = lookup(key);
                    if (slot >= 0) begin
                        push(K_GET_HIT, key, vals[slot]);
                        touch(slot);
                    end else begin
                        miss_key = key;
                        miss_valid = 1'b1;
                        push(K_FETCH, key, '0);
                    end
                end
                REQ_SET: begin
                    slot = lookup(key);
                    if (slot >= 0) begin
                        vals[slot] = v;
                        dirty[slot] = 1'b1;
                        touch(slot);
                    end else begin
                        insert(key, v, 1'b1);
                    end
                    push(K_SET_DONE, key, v);
                end
                REQ_FILL: begin
                    if (!miss_valid) begin
                        push(K_FILL_FAIL, key, '0);
                    end else begin
                        pk = miss_key;
                        miss_valid = 1'b0;
                        if (!ok) begin
                            push(K_FILL_FAIL, pk, '0);
                        end else begin
                            slot = lookup(pk);
                            if (slot >= 0) begin
                                push(K_FILL_DONE, pk, vals[slot]);
                                touch(slot);
                            end else begin
                                insert(pk, v, 1'b0);
                                push(K_FILL_DONE, pk, v);
                            end
                        end
                    end
                end
                default: begin
                    for (int i = 0; i < used; i++)
                        if (dirty[i]) push(K_WRITEBACK, keys[i], vals[i]);
                    used = 0;
                    foreach (dirty[i]) dirty[i] = 1'b0;
                    push(K_FLUSH_DONE, key, '0);
                end
            endcase
            burst[burst.size()-1].last = 1'b1;
            foreach (burst[i]) awaited.push_back(burst[i]);
        endfunction

        function void check_result(logic [2:0] kind, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] v, logic last);
            t_cache_word w;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected word kind %0d key %h value %h last %b",
                         $time, kind, key, v, last);
                errors++;
                return;
            end
            w = awaited.pop_front();
            if (kind !== w.kind || key !== w.key || v !== w.value || last !== w.last) begin
                $display("%0t: mismatch expected kind %0d key %h value %h last %b",
                         $time, w.kind, w.key, w.value, w.last);
                $display("%0t:          actual   kind %0d key %h value %h last %b",
                         $time, kind, key, v, last);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       i_req_type;
    logic [KEY_W-1:0] i_key;
    logic [VAL_W-1:0] i_value;
    logic             i_fill_ok;
    logic             o_res_valid;
    logic [2:0]       o_kind;
    logic [KEY_W-1:0] o_out_key;
    logic [VAL_W-1:0] o_out_value;
    logic             o_last;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data;

    key_cache_shadow shadow;
    int  quiet_cycles;
    bit  no_idle;
    logic [KEY_W-1:0] key_pool [12];

    lru_writeback_key_cache_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_key(i_key), .i_value(i_value),
        .i_fill_ok(i_fill_ok), .o_res_valid(o_res_valid), .o_kind(o_kind),
        .o_out_key(o_out_key), .o_out_value(o_out_value), .o_last(o_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid)
            shadow.check_result(o_kind, o_out_key, o_out_value, o_last);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog expired", $time);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(t_req req, logic [KEY_W-1:0] key,
                                logic [VAL_W-1:0] v, logic ok);
        int gap;
        if (!no_idle && $urandom_range(99) < 13) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= req;
        i_key <= key;
        i_value <= v;
        i_fill_ok <= ok;
        do @(posedge i_clk); while (busy);
        shadow.note_request(req, key, v, ok);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] c);
        start <= 1'b0;
        @(posedge i_clk);
        while (shadow.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow.set_capacity(c);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(9) == 0) return KEY_W'($urandom());
        return key_pool[$urandom_range(11)];
    endfunction

    task automatic random_burst(int count);
        logic [KEY_W-1:0] k;
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            k = pick_key();
            if (r < 40) begin
                send_request(REQ_GET, k, $urandom(), 1'($urandom_range(1)));
                // usually answer the miss right away
                if ($urandom_range(9) < 7)
                    send_request(REQ_FILL, pick_key(), $urandom(), $urandom_range(9) != 0);
            end else if (r < 80) begin
                send_request(REQ_SET, k, $urandom(), 1'($urandom_range(1)));
            end else if (r < 95) begin
                send_request(REQ_FILL, k, $urandom(), 1'($urandom_range(1)));
            end else begin
                send_request(REQ_FLUSH, k, $urandom(), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        logic [CAP_W-1:0] caps [8];
        shadow = new();
        no_idle = 1'b0;
        caps = '{CAP_W'(1), CAP_W'(0), CAP_W'(31), CAP_W'(2), CAP_W'(20),
                 CAP_W'(5), CAP_W'(16), CAP_W'(3)};
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 12; i++) key_pool[i] = KEY_W'($urandom());
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = REQ_GET;
        i_key = '0;
        i_value = '0;
        i_fill_ok = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every request and the corner cases
        send_request(REQ_FILL, 32'h1234_5678, '1, 1'b1);       // fill with nothing pending
        send_request(REQ_SET, '0, '0, 1'b0);
        send_request(REQ_SET, '1, '1, 1'b1);
        send_request(REQ_GET, '0, '1, 1'b1);
        send_request(REQ_GET, '1, '0, 1'b0);
        send_request(REQ_SET, '0, 32'hA5A5_5A5A, 1'b0);        // set hit marks dirty
        send_request(REQ_GET, 32'h0000_00AA, '0, 1'b0);
        send_request(REQ_FILL, '1, 32'hCAFE_F00D, 1'b1);       // fill ignores its key
        send_request(REQ_GET, 32'h0000_00AA, '0, 1'b0);
        send_request(REQ_GET, 32'h0000_00BB, '0, 1'b0);
        send_request(REQ_FILL, '0, '1, 1'b0);                  // failed fill
        send_request(REQ_GET, 32'h0000_00CC, '0, 1'b0);
        send_request(REQ_GET, 32'h0000_00DD, '0, 1'b0);        // newer miss replaces pending
        send_request(REQ_SET, 32'h0000_00DD, 32'h1111_2222, 1'b0);
        send_request(REQ_FILL, '0, 32'h3333_4444, 1'b1);       // key set meanwhile
        send_request(REQ_GET, 32'h0000_00EE, '0, 1'b0);
        send_request(REQ_FLUSH, 32'h5555_AAAA, '1, 1'b1);      // pending miss survives flush
        send_request(REQ_FILL, '0, 32'h7777_8888, 1'b1);
        send_request(REQ_FLUSH, '1, '0, 1'b0);
        for (int i = 0; i < 17; i++)
            send_request(REQ_SET, KEY_W'(i + 100), VAL_W'(i), 1'b0);  // fills past capacity

        random_burst(20);
        foreach (caps[p]) begin
            write_capacity(caps[p]);
            no_idle = (p == 3);
            random_burst(25);
        end
        no_idle = 1'b0;

        start <= 1'b0;
        while (shadow.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.awaited.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
